// File: rtl/core/ced_pkg.sv
// shared types and codes for the character edit distance engine
`timescale 1ns / 1ps

package ced_pkg;

  localparam int CHAR_W = 32;
  localparam int OUT_W  = 8;

  // command codes carried in func
  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_WORD   = 2'd2,
    FUNC_EMPTY  = 2'd3
  } func_t;

  // control travelling with the wavefront along the cell chain
  typedef struct packed {
    logic go;   // wavefront present at this stage
    logic upd;  // cells rewrite their distance (clear on overlong word)
  } wave_ctl_t;

endpackage

// File: rtl/core/ced_cell.sv
// one key cell: stores a key character and one distance entry of the row
`timescale 1ns / 1ps

module ced_cell #(
  parameter int IDX        = 0,
  parameter int NUM_CELLS  = 32,
  parameter int DIST_WIDTH = 8,
  localparam int LW        = $clog2(NUM_CELLS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        init,
  input  logic                        key_we,
  input  logic [ced_pkg::CHAR_W-1:0]  key_char,
  input  logic [LW-1:0]               key_length,
  input  ced_pkg::wave_ctl_t          ctl_in,
  input  logic [ced_pkg::CHAR_W-1:0]  ch_in,
  input  logic [DIST_WIDTH-1:0]       new_in,
  input  logic [DIST_WIDTH-1:0]       old_in,
  output ced_pkg::wave_ctl_t          ctl_out,
  output logic [ced_pkg::CHAR_W-1:0]  ch_out,
  output logic [DIST_WIDTH-1:0]       new_out,
  output logic [DIST_WIDTH-1:0]       old_out
);
  import ced_pkg::*;

  localparam int DMAX = (1 << DIST_WIDTH) - 1;
  localparam int INIT = (IDX + 1 > DMAX) ? DMAX : IDX + 1;
  localparam logic [DIST_WIDTH-1:0] DMAX_V = DIST_WIDTH'(DMAX);
  localparam logic [DIST_WIDTH-1:0] INIT_V = DIST_WIDTH'(INIT);

  logic [CHAR_W-1:0]     key;
  logic [DIST_WIDTH-1:0] row_val;
  logic                  active;
  logic [DIST_WIDTH-1:0] m_lo;
  logic [DIST_WIDTH-1:0] m_all;
  logic [DIST_WIDTH-1:0] v;

  // cells past the key length only forward the wavefront
  assign active = key_length > LW'(IDX);

  always_comb begin
    m_lo  = (row_val < new_in) ? row_val : new_in;
    m_all = (m_lo < old_in) ? m_lo : old_in;
    if (key == ch_in) begin
      v = old_in;
    end else if (m_all == DMAX_V) begin
      v = DMAX_V;
    end else begin
      v = m_all + DIST_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_val <= '0;
      ctl_out <= '0;
    end else begin
      if (init) begin
        row_val <= INIT_V;
      end else if (ctl_in.go && ctl_in.upd && active) begin
        row_val <= v;
      end
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we && key_length == LW'(IDX)) begin
      key <= key_char;
    end
    ch_out  <= ch_in;
    new_out <= active ? (ctl_in.upd ? v : row_val) : new_in;
    old_out <= active ? row_val : old_in;
  end

endmodule

// File: rtl/core/char_edit_distance_engine_core.sv
// top level of the character edit distance engine: control and cell chain
`timescale 1ns / 1ps

// usage
//   request channel (req_valid / req_stall) carries one command word: func,
//   character, first, last. a word is taken when req_valid is high and
//   req_stall is low. result channel (rsp_valid / rsp_stall) carries
//   distance and truncated, same rule with the stall driven by the receiver.
//   clear and append words are taken back to back.
//   a word character launches a wavefront down a chain of MAX_KEY_CHARS
//   cells, one cell per cycle, so the next word is taken only once the
//   wavefront has left the last cell, and after a last character only once
//   the result has moved on to the output register. an empty-word command
//   holds the input until its result has moved on to the output register.
//   the results of a last character and of an empty-word command wait in
//   the emit state and load the output register once that register is free.
//   the result sits in an output register: while the receiver stalls it,
//   the engine keeps taking words, and only holds off when a new result
//   would need that register.
//   reset (rst, synchronous) empties the key, zeroes the distance row and
//   word counters and drops any pending result.
module char_edit_distance_engine_core #(
  parameter int MAX_KEY_CHARS = 32,
  parameter int DIST_WIDTH    = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  ced_pkg::func_t              func,
  input  logic [ced_pkg::CHAR_W-1:0]  character,
  input  logic                        first,
  input  logic                        last,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [ced_pkg::OUT_W-1:0]   distance,
  output logic                        truncated
);
  import ced_pkg::*;

  localparam int LW = $clog2(MAX_KEY_CHARS + 1);
  localparam logic [16:0] DMAX17 = 17'((1 << DIST_WIDTH) - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAVE = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  // saturate to the distance width
  function automatic logic [DIST_WIDTH-1:0] sat_dist(input logic [16:0] val);
    return (val > DMAX17) ? DIST_WIDTH'(DMAX17) : DIST_WIDTH'(val);
  endfunction

  // clamp to the 8-bit output range
  function automatic logic [OUT_W-1:0] clamp_out(input logic [16:0] val);
    return (val > 17'd255) ? 8'hFF : val[7:0];
  endfunction

  state_t                state;
  logic [LW-1:0]         klen;
  logic                  kovf;
  logic [7:0]            pos;
  logic                  wovf;
  logic [DIST_WIDTH-1:0] d0;        // column zero of the row
  logic                  last_r;
  logic [OUT_W-1:0]      pend_dist;
  logic                  pend_trunc;

  wave_ctl_t             launch_ctl;
  wave_ctl_t             launch_ctl_next;
  logic [CHAR_W-1:0]     launch_ch;
  logic [DIST_WIDTH-1:0] launch_new;
  logic [DIST_WIDTH-1:0] launch_old;

  wave_ctl_t             ctl_w [0:MAX_KEY_CHARS];
  logic [CHAR_W-1:0]     ch_w  [0:MAX_KEY_CHARS];
  logic [DIST_WIDTH-1:0] new_w [0:MAX_KEY_CHARS];
  logic [DIST_WIDTH-1:0] old_w [0:MAX_KEY_CHARS];

  logic                  req_acc;
  logic                  out_free;
  logic                  key_room;
  logic                  key_we;
  logic                  row_init;
  logic [7:0]            pos_base;
  logic                  wovf_base;
  logic [DIST_WIDTH-1:0] d0_base;
  logic                  pos_full;
  logic [DIST_WIDTH-1:0] d0_inc;

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign key_room  = klen < LW'(MAX_KEY_CHARS);
  assign key_we    = req_acc && func == FUNC_APPEND && key_room;
  assign row_init  = req_acc && func == FUNC_WORD && first;

  // a first character restarts the row from the column-zero side here;
  // the cells reload their own start values on row_init
  assign pos_base  = first ? 8'd0 : pos;
  assign wovf_base = first ? 1'b0 : wovf;
  assign d0_base   = first ? '0 : d0;
  assign pos_full  = (pos_base == 8'hFF);
  assign d0_inc    = sat_dist(17'(pos_base) + 17'd1);

  // wavefront launch control, an overlong word moves no cell
  always_comb begin
    launch_ctl_next     = '0;
    launch_ctl_next.go  = req_acc && func == FUNC_WORD;
    launch_ctl_next.upd = !pos_full;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      klen       <= '0;
      kovf       <= 1'b0;
      pos        <= '0;
      wovf       <= 1'b0;
      d0         <= '0;
      launch_ctl <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      launch_ctl <= launch_ctl_next;
      if (state == S_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc) begin
            case (func)
              FUNC_CLEAR: begin
                klen <= '0;
                kovf <= 1'b0;
              end
              FUNC_APPEND: begin
                if (key_room) begin
                  klen <= klen + LW'(1);
                end else begin
                  kovf <= 1'b1;
                end
              end
              FUNC_WORD: begin
                state <= S_WAVE;
                wovf  <= wovf_base | pos_full;
                pos   <= pos_full ? pos_base : pos_base + 8'd1;
                d0    <= pos_full ? d0_base : d0_inc;
              end
              FUNC_EMPTY: begin
                state <= S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_WAVE: begin
          // wavefront has left the last cell
          if (ctl_w[MAX_KEY_CHARS].go) begin
            state <= last_r ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      launch_ch  <= character;
      launch_new <= pos_full ? d0_base : d0_inc;
      launch_old <= d0_base;
      last_r     <= last;
      if (func == FUNC_EMPTY) begin
        pend_dist  <= clamp_out(17'(sat_dist(17'(klen))));
        pend_trunc <= kovf;
      end
    end
    if (state == S_WAVE && ctl_w[MAX_KEY_CHARS].go) begin
      // chain tail carries the row entry at the key length
      pend_dist  <= clamp_out(17'(new_w[MAX_KEY_CHARS]));
      pend_trunc <= kovf | wovf;
    end
    if (state == S_EMIT && out_free) begin
      distance  <= pend_dist;
      truncated <= pend_trunc;
    end
  end

  // cell chain, column zero feeds the head
  assign ctl_w[0] = launch_ctl;
  assign ch_w[0]  = launch_ch;
  assign new_w[0] = launch_new;
  assign old_w[0] = launch_old;

  for (genvar g = 0; g < MAX_KEY_CHARS; g++) begin : g_cell
    ced_cell #(
      .IDX        (g),
      .NUM_CELLS  (MAX_KEY_CHARS),
      .DIST_WIDTH (DIST_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .init       (row_init),
      .key_we     (key_we),
      .key_char   (character),
      .key_length (klen),
      .ctl_in     (ctl_w[g]),
      .ch_in      (ch_w[g]),
      .new_in     (new_w[g]),
      .old_in     (old_w[g]),
      .ctl_out    (ctl_w[g+1]),
      .ch_out     (ch_w[g+1]),
      .new_out    (new_w[g+1]),
      .old_out    (old_w[g+1])
    );
  end

  // checks
  a_tail_in_wave: assert property (@(posedge clk) disable iff (rst)
    ctl_w[MAX_KEY_CHARS].go |-> state == S_WAVE)
    else $error("wavefront left the chain outside a wave");

  a_launch_in_wave: assert property (@(posedge clk) disable iff (rst)
    launch_ctl.go |-> state == S_WAVE)
    else $error("wavefront launched outside a wave");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> rsp_valid)
    else $error("pending result not loaded");

  a_klen_bound: assert property (@(posedge clk) disable iff (rst)
    klen <= LW'(MAX_KEY_CHARS))
    else $error("key length beyond cell count");

  a_wovf_pos: assert property (@(posedge clk) disable iff (rst)
    wovf |-> pos == 8'hFF)
    else $error("word overflow without full position");

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the character edit distance engine core
`timescale 1ns / 1ps

// what is covered
//   a scoreboard keeps its own copy of the key store, the distance row and
//   the word counters, and replays every accepted command word against it.
//   each result word is matched, field by field, with the oldest score
//   still waiting.
//   stimulus runs in named phases: hand-picked corner words, a key that
//   runs past its store, candidates long enough to hit the length limit,
//   then random sessions of key loads and candidates with some noise mixed in.
//   both handshakes idle at random. inputs move on the falling edge and
//   everything is sampled on the rising edge.
module tb_top;

  import ced_pkg::*;

  localparam int MAX_KEY        = 32;
  localparam int DIST_W         = 8;
  localparam int DIST_MAX       = (1 << DIST_W) - 1;
  localparam int POS_MAX        = 255;
  localparam int WATCHDOG_LIMIT = 2000;
  // wavefront runs the whole cell chain, plus margin for stray results
  localparam int DRAIN_CYCLES   = MAX_KEY + 8;

  // score the engine should report for one finished candidate
  typedef struct {
    logic [OUT_W-1:0] dval;
    logic             trunc;
  } score_t;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  func_t             func;
  logic [CHAR_W-1:0] character;
  logic              first;
  logic              last;
  logic              rsp_valid;
  logic              rsp_stall;
  logic [OUT_W-1:0]  distance;
  logic              truncated;

  // scoreboard copy of the engine state
  logic [CHAR_W-1:0] key_mem [MAX_KEY];
  int unsigned       key_len  = 0;
  logic              key_ovf  = 1'b0;
  logic [DIST_W-1:0] edit_row [MAX_KEY + 1];
  logic [7:0]        word_pos = '0;
  logic              word_ovf = 1'b0;

  score_t            expected_scores [$];
  logic [CHAR_W-1:0] alphabet [4];
  int unsigned       words_issued = 0;
  int unsigned       mismatches   = 0;
  int unsigned       quiet_cycles = 0;
  // when set, neither side idles
  bit                calm = 1'b0;

  char_edit_distance_engine_core #(
    .MAX_KEY_CHARS (MAX_KEY),
    .DIST_WIDTH    (DIST_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .character (character),
    .first     (first),
    .last      (last),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .distance  (distance),
    .truncated (truncated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length for either side: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DIST_W-1:0] clamp_dist(int unsigned v);
    if (v > DIST_MAX) return DIST_W'(DIST_MAX);
    return DIST_W'(v);
  endfunction

  // append one expected score at the tail of the queue
  task automatic queue_score(logic [OUT_W-1:0] d, logic t);
    score_t s;
    s.dval  = d;
    s.trunc = t;
    expected_scores.insert(expected_scores.size(), s);
  endtask

  // replay one accepted command word on the scoreboard state
  task automatic advance_edit_row(func_t f, logic [CHAR_W-1:0] c, logic fi, logic la);
    int unsigned diag;
    int unsigned up;
    int unsigned best;
    case (f)
      FUNC_CLEAR: begin
        key_len = 0;
        key_ovf = 1'b0;
      end
      FUNC_APPEND: begin
        // a full store drops the character and flags the key
        if (key_len < MAX_KEY) begin
          key_mem[key_len] = c;
          key_len++;
        end else begin
          key_ovf = 1'b1;
        end
      end
      FUNC_EMPTY: begin
        // empty candidate: distance is the key length, word state untouched
        queue_score(OUT_W'(clamp_dist(key_len)), key_ovf);
      end
      FUNC_WORD: begin
        // first mark restarts the row at 0, 1, 2 ... and clears the counters
        if (fi) begin
          for (int i = 0; i <= MAX_KEY; i++) edit_row[i] = clamp_dist(i);
          word_pos = '0;
          word_ovf = 1'b0;
        end
        // past the length limit the character is ignored but flagged
        if (word_pos == POS_MAX) begin
          word_ovf = 1'b1;
        end else begin
          diag = edit_row[0];
          word_pos++;
          edit_row[0] = clamp_dist(word_pos);
          // only cells below the key length move; cells appended mid-word
          // keep whatever the row start gave them
          for (int i = 1; i <= key_len; i++) begin
            up = edit_row[i];
            if (key_mem[i - 1] == c) begin
              edit_row[i] = DIST_W'(diag);
            end else begin
              best = up;
              if (edit_row[i - 1] < best) best = edit_row[i - 1];
              if (diag < best) best = diag;
              edit_row[i] = clamp_dist(best + 1);
            end
            diag = up;
          end
        end
        // output is 8 bits wide, same as the row at this distance width
        if (la) queue_score(OUT_W'(edit_row[key_len]), key_ovf | word_ovf);
      end
      default: begin
      end
    endcase
  endtask

  // hand one command word over and replay it once it is taken
  task automatic issue_word(func_t f, logic [CHAR_W-1:0] c, logic fi, logic la);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    // valid stays high into the next word when there is no gap
    req_valid <= 1'b1;
    func      <= f;
    character <= c;
    first     <= fi;
    last      <= la;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    advance_edit_row(f, c, fi, la);
    words_issued++;
  endtask

  // mostly letters of a small alphabet so that matches are common
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return alphabet[$urandom_range(0, 3)];
    if (r < 85 && key_len > 0) return key_mem[$urandom_range(0, key_len - 1)];
    return $urandom;
  endfunction

  // clear, then append n characters; past the store they overflow
  task automatic load_key(int n);
    alphabet[0] = $urandom;
    // a neighbour one bit away stresses the full-width compare
    alphabet[1] = alphabet[0] ^ (32'd1 << $urandom_range(0, 31));
    alphabet[2] = $urandom;
    alphabet[3] = $urandom;
    issue_word(FUNC_CLEAR, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    for (int k = 0; k < n; k++)
      issue_word(FUNC_APPEND, ($urandom_range(0, 4) != 0) ? alphabet[$urandom_range(0, 3)]
                 : logic'(1'b0) ? '0 : $urandom,
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // stream one candidate; mimic keeps it close to the key
  task automatic send_candidate(int len, bit mark_first, bit mark_last, bit mimic);
    logic [CHAR_W-1:0] c;
    for (int p = 0; p < len; p++) begin
      if (mimic && p < key_len && $urandom_range(0, 9) < 8) c = key_mem[p];
      else c = pick_char();
      issue_word(FUNC_WORD, c, mark_first && p == 0, mark_last && p == len - 1);
    end
  endtask

  // corner words: field extremes, every command, the odd sequences
  task automatic test_directed();
    // candidate with no first mark straight after reset runs on the reset row
    issue_word(FUNC_WORD, 32'hFFFF_FFFF, 1'b0, 1'b1);
    // empty candidate ignores its first and last bits
    issue_word(FUNC_EMPTY, 32'h0000_0000, 1'b1, 1'b1);
    // clear and append ignore their marks too
    issue_word(FUNC_CLEAR, 32'hFFFF_FFFF, 1'b1, 1'b1);
    issue_word(FUNC_APPEND, 32'h0000_0000, 1'b1, 1'b1);
    issue_word(FUNC_APPEND, 32'hFFFF_FFFF, 1'b0, 1'b0);
    issue_word(FUNC_APPEND, 32'h4100_0000, 1'b1, 1'b0);
    // exact match
    issue_word(FUNC_WORD, 32'h0000_0000, 1'b1, 1'b0);
    issue_word(FUNC_WORD, 32'hFFFF_FFFF, 1'b0, 1'b0);
    issue_word(FUNC_WORD, 32'h4100_0000, 1'b0, 1'b1);
    // the same candidate carries on without a first mark
    issue_word(FUNC_WORD, 32'h4100_0000, 1'b0, 1'b1);
    // one character that matches nothing
    issue_word(FUNC_WORD, 32'h8000_0000, 1'b1, 1'b1);
    issue_word(FUNC_EMPTY, 32'hFFFF_FFFF, 1'b0, 1'b0);
    // key grows while a candidate is under way
    issue_word(FUNC_WORD, 32'h4100_0000, 1'b1, 1'b0);
    issue_word(FUNC_APPEND, 32'h4200_0000, 1'b0, 1'b0);
    issue_word(FUNC_WORD, 32'h4200_0000, 1'b0, 1'b1);
    // one bit away from a key character is a different character
    issue_word(FUNC_WORD, 32'h0000_0001, 1'b1, 1'b1);
    issue_word(FUNC_CLEAR, 32'h0000_0000, 1'b0, 1'b0);
    issue_word(FUNC_EMPTY, 32'h0000_0000, 1'b0, 1'b0);
  endtask

  // full key store, then two characters too many
  task automatic test_key_overflow();
    load_key(MAX_KEY + 2);
    issue_word(FUNC_EMPTY, $urandom, 1'b0, 1'b0);
    send_candidate(3, 1'b1, 1'b1, 1'b1);
    send_candidate(MAX_KEY, 1'b1, 1'b1, 1'b1);
    // clear drops the overflow flag
    issue_word(FUNC_CLEAR, $urandom, 1'b0, 1'b0);
    issue_word(FUNC_EMPTY, $urandom, 1'b0, 1'b0);
  endtask

  // candidate right at the length limit, then one character past it
  task automatic test_long_candidate();
    load_key(0);
    send_candidate(POS_MAX, 1'b1, 1'b1, 1'b0);
    issue_word(FUNC_WORD, pick_char(), 1'b0, 1'b1);
    // a fresh candidate starts clean again
    load_key(3);
    send_candidate(3, 1'b1, 1'b1, 1'b1);
  endtask

  // random sessions: mostly well-formed key loads and candidates
  task automatic test_random_sessions(int unsigned target);
    int r;
    int n;
    int unsigned stop_at;
    stop_at = words_issued + target;
    while (words_issued < stop_at) begin
      calm = ($urandom_range(0, 6) == 0);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        n = $urandom_range(0, 99);
        if (n < 70) n = $urandom_range(0, 8);
        else if (n < 92) n = $urandom_range(9, MAX_KEY);
        else n = $urandom_range(MAX_KEY + 1, MAX_KEY + 3);
        load_key(n);
      end else if (r < 78) begin
        send_candidate($urandom_range(1, 10), 1'b1, 1'b1, $urandom_range(0, 2) == 0);
      end else if (r < 86) begin
        issue_word(FUNC_EMPTY, $urandom, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end else if (r < 93) begin
        // broken candidates: missing first or last marks
        send_candidate($urandom_range(1, 4), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'b0);
      end else begin
        issue_word(func_t'($urandom_range(0, 3)), $urandom,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    calm = 1'b0;
  endtask

  // result side: stall in runs, with open stretches in between
  initial begin : result_stall
    int n;
    rsp_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // compare each taken result with the oldest waiting score
  always @(posedge clk) begin : score_check
    score_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_scores.size() == 0) begin
        $error("result with no score waiting: distance=%0d truncated=%0b",
               distance, truncated);
        mismatches++;
      end else begin
        want = expected_scores.pop_front();
        if (distance !== want.dval) begin
          $error("distance: expected %0d, got %0d", want.dval, distance);
          mismatches++;
        end
        if (truncated !== want.trunc) begin
          $error("truncated: expected %0b, got %0b", want.trunc, truncated);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long with no word taken on either side
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL char_edit_distance_engine_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    func      = FUNC_CLEAR;
    character = '0;
    first     = 1'b0;
    last      = 1'b0;
    for (int i = 0; i <= MAX_KEY; i++) edit_row[i] = '0;
    for (int i = 0; i < 4; i++) alphabet[i] = 32'h6100_0000 + i;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_key_overflow();
    test_long_candidate();
    test_random_sessions(950);

    @(negedge clk);
    req_valid <= 1'b0;
    // every score must come back; the watchdog bounds this wait
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS char_edit_distance_engine_core");
    else $display("FAIL char_edit_distance_engine_core");
    $finish;
  end

endmodule
